// ===== sv/msq_pkg.sv =====
`timescale 1ns / 1ps

package msq_pkg;

  localparam int LINE_SAMPLES_DEF = 4096;
  localparam int MAX_CHANNELS_DEF = 4;

  localparam int PIX_W      = 8;
  localparam int CH_W       = 3;
  localparam int WIDTH_W    = 13;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 13;
  localparam int NUM_LINES  = 3;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_CHANNELS = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_WIDTH    = 1'd1;

  localparam logic [CH_W-1:0]    CHANNELS_RST = 3'd1;
  localparam logic [WIDTH_W-1:0] WIDTH_RST    = 13'd640;

  typedef logic [PIX_W-1:0] pix_t;
  typedef logic [1:0]       buf_idx_t;

  typedef enum logic [1:0] {
    PH_FIRST,
    PH_BODY,
    PH_FLUSH
  } phase_t;

  // which physical line plays which role for one request
  typedef struct packed {
    buf_idx_t cur;
    buf_idx_t older;
    buf_idx_t newer;
    logic     use_newer;
  } bufsel_t;

  // results owed by one request
  typedef struct packed {
    logic            emit;
    logic            row_end;
    logic            frame_end;
    logic            left_ok;
    logic [CH_W-1:0] ch;
  } job_t;

  // one column of the neighbourhood, sorted
  typedef struct packed {
    pix_t lo;
    pix_t mid;
    pix_t hi;
  } col_t;

  typedef struct packed {
    pix_t lo_max;
    pix_t mid_med;
    pix_t hi_min;
    logic row_end;
    logic frame_end;
    logic last;
  } m1_t;

  function automatic pix_t min2(input pix_t a, input pix_t b);
    return (a < b) ? a : b;
  endfunction

  function automatic pix_t max2(input pix_t a, input pix_t b);
    return (a > b) ? a : b;
  endfunction

  function automatic pix_t med3(input pix_t a, input pix_t b, input pix_t c);
    return max2(min2(a, b), min2(max2(a, b), c));
  endfunction

  function automatic col_t sort3(input pix_t a, input pix_t b, input pix_t c);
    col_t s;
    s.lo  = min2(min2(a, b), c);
    s.hi  = max2(max2(a, b), c);
    s.mid = med3(a, b, c);
    return s;
  endfunction

  // lowest line index that is neither of the two given
  function automatic buf_idx_t free_buf(input buf_idx_t a, input buf_idx_t b);
    buf_idx_t f;
    if (a != 2'd0 && b != 2'd0) begin
      f = 2'd0;
    end else if (a != 2'd1 && b != 2'd1) begin
      f = 2'd1;
    end else begin
      f = 2'd2;
    end
    return f;
  endfunction

endpackage

// ===== sv/msq_in_if.sv =====
`timescale 1ns / 1ps

interface msq_in_if
  import msq_pkg::*;
();
  logic valid;
  logic ready;
  pix_t sample;
  logic flush;

  modport source (output valid, output sample, output flush, input ready);
  modport sink (input valid, input sample, input flush, output ready);
endinterface

// ===== sv/msq_out_if.sv =====
`timescale 1ns / 1ps

interface msq_out_if
  import msq_pkg::*;
();
  logic valid;
  logic ready;
  pix_t median;
  logic row_end;
  logic frame_end;
  logic last;

  modport source (output valid, output median, output row_end, output frame_end,
                  output last, input ready);
  modport sink (input valid, input median, input row_end, input frame_end,
                input last, output ready);
endinterface

// ===== sv/median_square_3x3_u8.sv =====
`timescale 1ns / 1ps

// 3x3 median filter over a raster stream of 8-bit samples with 1 to 4
// interleaved channels, edges replicated on all four borders. One sample
// request can be taken every clock while the pipeline is not stalled. Results
// for row r-1 come out while row r goes in, one per clock while the output is
// ready. A result goes through the request, sorted-column, partial-median and
// output registers once the request that completes its neighbourhood is taken.
// The sample that closes a row owes channels+1 results. The window issues one
// result a clock while the output is free, so that sample holds the input until
// its results are issued. The first channels samples of the next row owe none.
// After the last row, send one full row of flush requests to push out the
// bottom row; frame_end marks its final result. Channels and width may be
// written only with the pipeline drained. A write takes effect at once, and a
// column past the new row end counts as the last column. Three line memories
// of LINE_SAMPLES bytes rotate between the older, newer and arriving row; no
// clearing pass is needed after reset.
module median_square_3x3_u8
  import msq_pkg::*;
#(
  parameter  int LINE_SAMPLES = LINE_SAMPLES_DEF,
  parameter  int MAX_CHANNELS = MAX_CHANNELS_DEF,
  localparam int AW           = $clog2(LINE_SAMPLES)
) (
  input  logic                  clk,
  input  logic                  rst_n,
  msq_in_if.sink                in_chan,
  msq_out_if.source             out_chan,
  input  logic                  cfg_wr_en,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  // request stage towards the line memories
  logic          s1_valid, s1_take;
  logic [AW-1:0] s1_addr;
  pix_t          s1_sample;
  bufsel_t       s1_sel;
  job_t          s1_job;
  logic          rd_en;
  logic [AW-1:0] rd_addr;

  // line memory write-back of the arriving row
  logic          wr_en;
  buf_idx_t      wr_buf;
  logic [AW-1:0] wr_addr;
  pix_t          wr_data;
  pix_t          rd_data [NUM_LINES];

  // sorted column stage and partial median stage
  logic          s2_valid, s2_take;
  col_t          s2_col;
  job_t          s2_job;
  logic          m1_valid, m1_take;
  m1_t           m1_data;

  // column counter, row phase, line rotation and the read of the rows above
  msq_ctrl #(
    .LINE_SAMPLES (LINE_SAMPLES),
    .MAX_CHANNELS (MAX_CHANNELS)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_chan   (in_chan),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .s1_take   (s1_take),
    .s1_valid  (s1_valid),
    .s1_addr   (s1_addr),
    .s1_sample (s1_sample),
    .s1_sel    (s1_sel),
    .s1_job    (s1_job),
    .rd_en     (rd_en),
    .rd_addr   (rd_addr)
  );

  // three rotating line memories, all read at the arriving column,
  // only the arriving row's line is written
  for (genvar i = 0; i < NUM_LINES; i++) begin : g_line
    msq_ram #(
      .WIDTH (PIX_W),
      .DEPTH (LINE_SAMPLES)
    ) u_ram (
      .clk     (clk),
      .wr_en   (wr_en && (wr_buf == buf_idx_t'(i))),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data[i])
    );
  end

  // assembles the vertical column, writes the arriving sample back, sorts it
  msq_column #(
    .LINE_SAMPLES (LINE_SAMPLES)
  ) u_column (
    .clk       (clk),
    .rst_n     (rst_n),
    .s1_valid  (s1_valid),
    .s1_addr   (s1_addr),
    .s1_sample (s1_sample),
    .s1_sel    (s1_sel),
    .s1_job    (s1_job),
    .rd_data   (rd_data),
    .s1_take   (s1_take),
    .wr_en     (wr_en),
    .wr_buf    (wr_buf),
    .wr_addr   (wr_addr),
    .wr_data   (wr_data),
    .s2_take   (s2_take),
    .s2_valid  (s2_valid),
    .s2_col    (s2_col),
    .s2_job    (s2_job)
  );

  // delay line of sorted columns and the sequencer that issues each result
  msq_window #(
    .MAX_CHANNELS (MAX_CHANNELS)
  ) u_window (
    .clk      (clk),
    .rst_n    (rst_n),
    .s2_valid (s2_valid),
    .s2_col   (s2_col),
    .s2_job   (s2_job),
    .s2_take  (s2_take),
    .m1_take  (m1_take),
    .m1_valid (m1_valid),
    .m1_data  (m1_data)
  );

  // final median of three and the output register
  msq_median u_median (
    .clk      (clk),
    .rst_n    (rst_n),
    .m1_valid (m1_valid),
    .m1_data  (m1_data),
    .m1_take  (m1_take),
    .out_chan (out_chan)
  );

endmodule

// ===== sv/msq_ram.sv =====
`timescale 1ns / 1ps

module msq_ram #(
  parameter  int WIDTH = 8,
  parameter  int DEPTH = 4096,
  localparam int AW    = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic             rd_en,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

// ===== sv/msq_ctrl.sv =====
`timescale 1ns / 1ps

module msq_ctrl
  import msq_pkg::*;
#(
  parameter  int LINE_SAMPLES = LINE_SAMPLES_DEF,
  parameter  int MAX_CHANNELS = MAX_CHANNELS_DEF,
  localparam int AW           = $clog2(LINE_SAMPLES)
) (
  input  logic                  clk,
  input  logic                  rst_n,
  msq_in_if.sink                in_chan,
  input  logic                  cfg_wr_en,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic                  s1_take,
  output logic                  s1_valid,
  output logic [AW-1:0]         s1_addr,
  output pix_t                  s1_sample,
  output bufsel_t               s1_sel,
  output job_t                  s1_job,
  output logic                  rd_en,
  output logic [AW-1:0]         rd_addr
);

  localparam int SW = AW + 1;
  localparam int DW = (SW > WIDTH_W) ? SW : WIDTH_W;
  localparam int PW = DW + CH_W;

  localparam logic [DW-1:0] MAXW1 = DW'(LINE_SAMPLES / 1);
  localparam logic [DW-1:0] MAXW2 = DW'(LINE_SAMPLES / 2);
  localparam logic [DW-1:0] MAXW3 = DW'(LINE_SAMPLES / 3);
  localparam logic [DW-1:0] MAXW4 = DW'(LINE_SAMPLES / 4);

  logic [CH_W-1:0]    chan_r;
  logic [WIDTH_W-1:0] width_r;
  phase_t             ph_r, ph_nxt, eph;
  logic [AW-1:0]      cc_r, cc_nxt;
  buf_idx_t           cur_r, cur_nxt, older_r, older_nxt, newer_r, newer_nxt;

  logic               s1_valid_r;
  logic [AW-1:0]      s1_addr_r;
  pix_t               s1_sample_r;
  bufsel_t            s1_sel_r;
  job_t               s1_job_r;

  logic [CH_W-1:0]    ch_eff;
  logic [DW-1:0]      maxw, wpx;
  logic [PW-1:0]      prod;
  logic [SW-1:0]      size, last_col;
  logic [AW-1:0]      col;
  logic               row_end, accept, ignore, work, in_ready;
  job_t               job;

  // effective row geometry
  always_comb begin
    ch_eff = chan_r;
    if (chan_r == '0) begin
      ch_eff = CH_W'(1);
    end else if (chan_r > CH_W'(MAX_CHANNELS)) begin
      ch_eff = CH_W'(MAX_CHANNELS);
    end
  end

  always_comb begin
    case (ch_eff)
      3'd2:    maxw = MAXW2;
      3'd3:    maxw = MAXW3;
      3'd4:    maxw = MAXW4;
      default: maxw = MAXW1;
    endcase
  end

  always_comb begin
    wpx = DW'(width_r);
    if (wpx < DW'(2)) begin
      wpx = DW'(2);
    end
    if (wpx > maxw) begin
      wpx = maxw;
    end
    prod     = PW'(wpx) * PW'(ch_eff);
    size     = prod[SW-1:0];
    last_col = size - SW'(1);
    col      = (SW'(cc_r) > last_col) ? last_col[AW-1:0] : cc_r;
    row_end  = (SW'(col) == last_col);
  end

  assign in_ready = !s1_valid_r || s1_take;
  assign accept   = in_chan.valid && in_ready;
  assign ignore   = (ph_r == PH_FIRST) && in_chan.flush;
  assign work     = accept && !ignore;

  // next state
  always_comb begin
    ph_nxt    = ph_r;
    cc_nxt    = cc_r;
    cur_nxt   = cur_r;
    older_nxt = older_r;
    newer_nxt = newer_r;
    if (work) begin
      if (row_end) begin
        cc_nxt = '0;
        case (eph)
          PH_FIRST: begin
            ph_nxt    = PH_BODY;
            older_nxt = cur_r;
            newer_nxt = cur_r;
            cur_nxt   = free_buf(cur_r, cur_r);
          end
          PH_BODY: begin
            ph_nxt    = PH_BODY;
            older_nxt = newer_r;
            newer_nxt = cur_r;
            cur_nxt   = free_buf(newer_r, cur_r);
          end
          PH_FLUSH: begin
            ph_nxt = PH_FIRST;
          end
          default: begin
            ph_nxt = PH_FIRST;
          end
        endcase
      end else begin
        ph_nxt = eph;
        cc_nxt = col + AW'(1);
      end
    end
  end

  // outputs of the phase logic
  always_comb begin
    eph = ph_r;
    if (ph_r == PH_BODY && in_chan.flush && cc_r == '0) begin
      eph = PH_FLUSH;
    end
    job.emit      = (eph != PH_FIRST) && (SW'(col) >= SW'(ch_eff));
    job.row_end   = (eph != PH_FIRST) && row_end;
    job.frame_end = (eph == PH_FLUSH) && row_end;
    job.left_ok   = SW'(col) >= (SW'(ch_eff) << 1);
    job.ch        = ch_eff;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      chan_r     <= CHANNELS_RST;
      width_r    <= WIDTH_RST;
      ph_r       <= PH_FIRST;
      cc_r       <= '0;
      cur_r      <= 2'd0;
      older_r    <= 2'd1;
      newer_r    <= 2'd2;
      s1_valid_r <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        case (cfg_index)
          REG_CHANNELS: chan_r  <= cfg_data[CH_W-1:0];
          REG_WIDTH:    width_r <= cfg_data[WIDTH_W-1:0];
          default:      ;
        endcase
      end
      ph_r    <= ph_nxt;
      cc_r    <= cc_nxt;
      cur_r   <= cur_nxt;
      older_r <= older_nxt;
      newer_r <= newer_nxt;
      if (work) begin
        s1_valid_r <= 1'b1;
      end else if (s1_take) begin
        s1_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (work) begin
      s1_addr_r             <= col;
      s1_sample_r           <= in_chan.sample;
      s1_sel_r.cur          <= cur_r;
      s1_sel_r.older        <= older_r;
      s1_sel_r.newer        <= newer_r;
      s1_sel_r.use_newer    <= (eph == PH_FLUSH) || in_chan.flush;
      s1_job_r              <= job;
    end
  end

  assign in_chan.ready = in_ready;
  assign s1_valid      = s1_valid_r;
  assign s1_addr       = s1_addr_r;
  assign s1_sample     = s1_sample_r;
  assign s1_sel        = s1_sel_r;
  assign s1_job        = s1_job_r;
  assign rd_en         = work;
  assign rd_addr       = col;

endmodule

// ===== sv/msq_column.sv =====
`timescale 1ns / 1ps

module msq_column
  import msq_pkg::*;
#(
  parameter  int LINE_SAMPLES = LINE_SAMPLES_DEF,
  localparam int AW           = $clog2(LINE_SAMPLES)
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          s1_valid,
  input  logic [AW-1:0] s1_addr,
  input  pix_t          s1_sample,
  input  bufsel_t       s1_sel,
  input  job_t          s1_job,
  input  pix_t          rd_data [NUM_LINES],
  output logic          s1_take,
  output logic          wr_en,
  output buf_idx_t      wr_buf,
  output logic [AW-1:0] wr_addr,
  output pix_t          wr_data,
  input  logic          s2_take,
  output logic          s2_valid,
  output col_t          s2_col,
  output job_t          s2_job
);

  logic s2_valid_r;
  pix_t s2_old_r, s2_new_r, s2_cur_r;
  job_t s2_job_r;
  pix_t old_pix, new_pix, cur_pix;

  assign old_pix = rd_data[s1_sel.older];
  assign new_pix = rd_data[s1_sel.newer];
  // flush items repeat the row above
  assign cur_pix = s1_sel.use_newer ? new_pix : s1_sample;

  assign s1_take = s1_valid && (!s2_valid_r || s2_take);

  assign wr_en   = s1_take;
  assign wr_buf  = s1_sel.cur;
  assign wr_addr = s1_addr;
  assign wr_data = cur_pix;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_valid_r <= 1'b0;
    end else if (s1_take) begin
      s2_valid_r <= 1'b1;
    end else if (s2_take) begin
      s2_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_take) begin
      s2_old_r <= old_pix;
      s2_new_r <= new_pix;
      s2_cur_r <= cur_pix;
      s2_job_r <= s1_job;
    end
  end

  assign s2_valid = s2_valid_r;
  assign s2_col   = sort3(s2_old_r, s2_new_r, s2_cur_r);
  assign s2_job   = s2_job_r;

endmodule

// ===== sv/msq_window.sv =====
`timescale 1ns / 1ps

module msq_window
  import msq_pkg::*;
#(
  parameter  int MAX_CHANNELS = MAX_CHANNELS_DEF,
  localparam int WIN_D        = 2 * MAX_CHANNELS + 1,
  localparam int WIN_IW       = $clog2(WIN_D)
) (
  input  logic clk,
  input  logic rst_n,
  input  logic s2_valid,
  input  col_t s2_col,
  input  job_t s2_job,
  output logic s2_take,
  input  logic m1_take,
  output logic m1_valid,
  output m1_t  m1_data
);

  col_t            win_r [WIN_D];
  logic            busy_r, row_end_r, frame_end_r, left_ok_r;
  logic [CH_W-1:0] d_r, end_d_r, ch_r;
  logic            m1_valid_r;
  m1_t             m1_r;

  logic            m1_free, issue, fin, e_free;
  logic [CH_W:0]   lft_sum, rgt_sum;
  logic [WIN_IW-1:0] lft_i, ctr_i, rgt_i;
  col_t            lc, cc, rc;
  m1_t             m1_nxt;

  assign m1_free = !m1_valid_r || m1_take;
  assign issue   = busy_r && m1_free;
  assign fin     = issue && (d_r == end_d_r);
  assign e_free  = !busy_r || fin;
  assign s2_take = s2_valid && e_free;

  // taps for the result d columns behind the newest one
  always_comb begin
    rgt_sum = (d_r >= ch_r) ? {1'b0, d_r - ch_r} : {1'b0, d_r};
    lft_sum = (d_r == ch_r && !left_ok_r) ? {1'b0, d_r}
                                          : {1'b0, d_r} + {1'b0, ch_r};
    lft_i   = lft_sum[WIN_IW-1:0];
    ctr_i   = WIN_IW'(d_r);
    rgt_i   = rgt_sum[WIN_IW-1:0];
    lc      = win_r[lft_i];
    cc      = win_r[ctr_i];
    rc      = win_r[rgt_i];
    m1_nxt.lo_max    = max2(max2(lc.lo, cc.lo), rc.lo);
    m1_nxt.mid_med   = med3(lc.mid, cc.mid, rc.mid);
    m1_nxt.hi_min    = min2(min2(lc.hi, cc.hi), rc.hi);
    m1_nxt.last      = (d_r == end_d_r);
    m1_nxt.row_end   = (d_r == end_d_r) && row_end_r;
    m1_nxt.frame_end = (d_r == end_d_r) && frame_end_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r     <= 1'b0;
      m1_valid_r <= 1'b0;
    end else begin
      if (s2_take) begin
        busy_r <= s2_job.emit;
      end else if (fin) begin
        busy_r <= 1'b0;
      end
      if (issue) begin
        m1_valid_r <= 1'b1;
      end else if (m1_take) begin
        m1_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s2_take) begin
      win_r[0] <= s2_col;
      for (int k = 1; k < WIN_D; k++) begin
        win_r[k] <= win_r[k-1];
      end
      d_r         <= s2_job.ch;
      end_d_r     <= s2_job.row_end ? '0 : s2_job.ch;
      ch_r        <= s2_job.ch;
      row_end_r   <= s2_job.row_end;
      frame_end_r <= s2_job.frame_end;
      left_ok_r   <= s2_job.left_ok;
    end else if (issue) begin
      d_r <= d_r - CH_W'(1);
    end
    if (issue) begin
      m1_r <= m1_nxt;
    end
  end

  assign m1_valid = m1_valid_r;
  assign m1_data  = m1_r;

endmodule

// ===== sv/msq_median.sv =====
`timescale 1ns / 1ps

module msq_median
  import msq_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       m1_valid,
  input  m1_t        m1_data,
  output logic       m1_take,
  msq_out_if.source  out_chan
);

  logic out_valid_r;
  pix_t median_r;
  logic row_end_r, frame_end_r, last_r;

  assign m1_take = m1_valid && (!out_valid_r || out_chan.ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (m1_take) begin
      out_valid_r <= 1'b1;
    end else if (out_chan.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (m1_take) begin
      median_r    <= med3(m1_data.lo_max, m1_data.mid_med, m1_data.hi_min);
      row_end_r   <= m1_data.row_end;
      frame_end_r <= m1_data.frame_end;
      last_r      <= m1_data.last;
    end
  end

  assign out_chan.valid     = out_valid_r;
  assign out_chan.median    = median_r;
  assign out_chan.row_end   = row_end_r;
  assign out_chan.frame_end = frame_end_r;
  assign out_chan.last      = last_r;

endmodule

// ===== test/msq_checker.sv =====
`timescale 1ns / 1ps

module msq_checker
  import msq_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  msq_in_if                     in_mon,
  msq_out_if                    out_mon,
  input  logic                  cfg_wr_en,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  output int                    err_count,
  output int                    pending
);

  localparam int LINE = LINE_SAMPLES_DEF;

  typedef struct packed {
    pix_t median;
    logic row_end;
    logic frame_end;
    logic last;
  } result_t;

  pix_t             line_old [LINE];
  pix_t             line_new [LINE];
  pix_t             line_cur [LINE];
  int unsigned      col_pos;
  phase_t           row_state;
  logic [CH_W-1:0]    reg_ch;
  logic [WIDTH_W-1:0] reg_w;
  result_t          owed_results [$];

  function automatic pix_t rank_median(input pix_t v [9]);
    int   below;
    int   not_above;
    pix_t m;
    m = v[0];
    for (int i = 0; i < 9; i++) begin
      below = 0;
      not_above = 0;
      for (int j = 0; j < 9; j++) begin
        if (v[j] < v[i]) below++;
        if (v[j] <= v[i]) not_above++;
      end
      if (below <= 4 && not_above >= 5) m = v[i];
    end
    return m;
  endfunction

  function automatic pix_t window_median(input int unsigned p, input int unsigned size,
                                         input int unsigned c);
    int unsigned l;
    int unsigned r;
    pix_t        v [9];
    if (p >= size) p = size - 1;
    l = (p >= c) ? p - c : p;
    r = (p + c < size) ? p + c : p;
    v[0] = line_old[l]; v[1] = line_old[p]; v[2] = line_old[r];
    v[3] = line_new[l]; v[4] = line_new[p]; v[5] = line_new[r];
    v[6] = line_cur[l]; v[7] = line_cur[p]; v[8] = line_cur[r];
    return rank_median(v);
  endfunction

  // works out the medians owed by one accepted sample request
  function automatic void filter_sample(input pix_t s, input logic f);
    int unsigned c;
    int unsigned wp;
    int unsigned size;
    int unsigned k;
    int unsigned start;
    int          n;
    result_t     res [MAX_CHANNELS_DEF+1];
    c = (reg_ch < 1) ? 1 : reg_ch;
    if (c > MAX_CHANNELS_DEF) c = MAX_CHANNELS_DEF;
    wp = (reg_w < 2) ? 2 : reg_w;
    if (wp > LINE / c) wp = LINE / c;
    size = wp * c;
    n = 0;

    if (row_state == PH_FIRST && f) return;
    if (row_state == PH_BODY && f && col_pos == 0) row_state = PH_FLUSH;

    k = (col_pos > size - 1) ? size - 1 : col_pos;
    line_cur[k] = (row_state == PH_FLUSH || f) ? line_new[k] : s;

    if (row_state != PH_FIRST && k >= c) begin
      res[n] = '{window_median(k - c, size, c), 1'b0, 1'b0, 1'b0};
      n++;
    end

    if (k + 1 >= size) begin
      if (row_state != PH_FIRST) begin
        start = (k + 1 >= c) ? k + 1 - c : 0;
        for (int unsigned p = start; p <= k; p++) begin
          res[n] = '{window_median(p, size, c), 1'b0, 1'b0, 1'b0};
          n++;
        end
        if (n > 0) begin
          res[n-1].row_end = 1'b1;
          if (row_state == PH_FLUSH) res[n-1].frame_end = 1'b1;
        end
      end
      case (row_state)
        PH_FIRST: begin
          line_new = line_cur;
          line_old = line_cur;
          row_state = PH_BODY;
        end
        PH_BODY: begin
          line_old = line_new;
          line_new = line_cur;
        end
        default: row_state = PH_FIRST;
      endcase
      col_pos = 0;
    end else begin
      col_pos = k + 1;
    end

    if (n > 0) res[n-1].last = 1'b1;
    for (int i = 0; i < n; i++) owed_results.push_back(res[i]);
  endfunction

  // sampled on the falling edge so that values are settled for the rising edge
  always @(negedge clk) begin
    result_t want;
    result_t got;
    if (!rst_n) begin
      col_pos = 0;
      row_state = PH_FIRST;
      reg_ch = CHANNELS_RST;
      reg_w = WIDTH_RST;
      owed_results.delete();
    end else begin
      if (cfg_wr_en) begin
        case (cfg_index)
          REG_CHANNELS: reg_ch = cfg_data[CH_W-1:0];
          REG_WIDTH:    reg_w = cfg_data[WIDTH_W-1:0];
          default: ;
        endcase
      end
      if (in_mon.valid && in_mon.ready) filter_sample(in_mon.sample, in_mon.flush);
      if (out_mon.valid && out_mon.ready) begin
        got = '{out_mon.median, out_mon.row_end, out_mon.frame_end, out_mon.last};
        if (owed_results.size() == 0) begin
          err_count++;
          $display("%0t: result with none owed, median %0d row_end %0b frame_end %0b last %0b",
                   $time, got.median, got.row_end, got.frame_end, got.last);
        end else begin
          want = owed_results.pop_front();
          if (got.median !== want.median) begin
            err_count++;
            $display("%0t: median expected %0d got %0d", $time, want.median, got.median);
          end
          if (got.row_end !== want.row_end) begin
            err_count++;
            $display("%0t: row_end expected %0b got %0b", $time, want.row_end, got.row_end);
          end
          if (got.frame_end !== want.frame_end) begin
            err_count++;
            $display("%0t: frame_end expected %0b got %0b", $time, want.frame_end,
                     got.frame_end);
          end
          if (got.last !== want.last) begin
            err_count++;
            $display("%0t: last expected %0b got %0b", $time, want.last, got.last);
          end
        end
      end
    end
    pending = owed_results.size();
  end

endmodule

// ===== test/tb_median_square_3x3_u8.sv =====
`timescale 1ns / 1ps

module tb_median_square_3x3_u8;
  import msq_pkg::*;

  // cycles with no request taken on either side before the run is given up
  localparam int unsigned WATCHDOG_LIMIT = 3000;
  // settling time after the last owed result
  localparam int unsigned DRAIN_PAD      = 16;
  // length of the one long receiver hold-off
  localparam int unsigned PRESSURE_HOLD  = 300;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  cfg_wr_en;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;
  int                    err_count;
  int                    pending;

  // stimulus state; quiet and pressure_req are shared between the sender and receiver processes
  bit                    quiet = 1'b0;
  bit                    pressure_req = 1'b0;
  bit                    pressure_done = 1'b0;
  logic [CH_W-1:0]       cur_ch = CHANNELS_RST;
  logic [WIDTH_W-1:0]    cur_w = WIDTH_RST;
  int unsigned           rand_items = 0;

  msq_in_if  in_if ();
  msq_out_if out_if ();

  median_square_3x3_u8 i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_chan   (in_if),
    .out_chan  (out_if),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  msq_checker i_chk (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_mon    (in_if),
    .out_mon   (out_if),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .err_count (err_count),
    .pending   (pending)
  );

  always #5 clk = ~clk;

  // idle length: mostly none or short, now and then a long one
  function automatic int unsigned gap_len();
    int unsigned r;
    if (quiet) return 0;
    r = $urandom_range(0, 99);
    if (r < 40) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  // sample values lean towards the extremes and towards near-ties
  function automatic pix_t pick_sample();
    int unsigned r;
    r = $urandom_range(0, 9);
    if (r == 0) return 8'd0;
    if (r == 1) return 8'd255;
    if (r == 2) return pix_t'($urandom_range(100, 102));
    return pix_t'($urandom_range(0, 255));
  endfunction

  // offer one request after a random gap and hold it until taken
  task automatic send_sample(input pix_t s, input logic f);
    int unsigned gap;
    gap = gap_len();
    if (gap > 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_if.valid  <= 1'b1;
    in_if.sample <= s;
    in_if.flush  <= f;
    // ready is looked at mid-cycle, when everything has settled
    do @(negedge clk); while (!in_if.ready);
    @(posedge clk);
  endtask

  // stop offering, wait for every owed result, then let the pipeline settle
  task automatic drain();
    in_if.valid <= 1'b0;
    while (pending != 0) @(posedge clk);
    repeat (DRAIN_PAD) @(posedge clk);
  endtask

  // registers only change with the block idle between frames
  task automatic configure(input logic [CH_W-1:0] ch, input logic [WIDTH_W-1:0] w);
    drain();
    cfg_wr_en <= 1'b1;
    cfg_index <= REG_CHANNELS;
    cfg_data  <= CFG_DATA_W'(ch);
    @(posedge clk);
    cfg_index <= REG_WIDTH;
    cfg_data  <= CFG_DATA_W'(w);
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    cur_ch = ch;
    cur_w  = w;
  endtask

  // one well-formed frame with random content: first row, body rows, flush row
  task automatic random_frame(input int unsigned nrows);
    int unsigned c;
    int unsigned wp;
    int unsigned size;
    int unsigned noise;
    c = (cur_ch < 1) ? 1 : cur_ch;
    if (c > MAX_CHANNELS_DEF) c = MAX_CHANNELS_DEF;
    wp = (cur_w < 2) ? 2 : cur_w;
    if (wp > LINE_SAMPLES_DEF / c) wp = LINE_SAMPLES_DEF / c;
    size = wp * c;

    // stray flush requests ahead of the frame are dropped by the block
    noise = ($urandom_range(0, 9) < 3) ? $urandom_range(1, 3) : 0;
    repeat (noise) send_sample(pick_sample(), 1'b1);

    // first row, now and then a dropped flush slipped in
    for (int unsigned i = 0; i < size; i++) begin
      if ($urandom_range(0, 99) < 5) send_sample(pick_sample(), 1'b1);
      send_sample(pick_sample(), 1'b0);
      rand_items++;
    end

    // body rows: a flush past column zero stands in for the sample above
    for (int unsigned r = 1; r < nrows; r++) begin
      for (int unsigned i = 0; i < size; i++) begin
        send_sample(pick_sample(), (i > 0) && ($urandom_range(0, 99) < 8));
        rand_items++;
      end
    end

    // the flush row: once begun, its flush bits no longer matter
    send_sample(pick_sample(), 1'b1);
    rand_items++;
    for (int unsigned i = 1; i < size; i++) begin
      send_sample(pick_sample(), logic'($urandom_range(0, 1)));
      rand_items++;
    end
  endtask

  // receiver: random stalls, plus one long hold-off on request
  initial begin
    int unsigned hold;
    int unsigned run;
    out_if.ready <= 1'b0;
    @(posedge clk);
    forever begin
      if (pressure_req && !pressure_done) begin
        hold = PRESSURE_HOLD;
        pressure_done = 1'b1;
      end else begin
        hold = gap_len();
      end
      if (hold > 0) begin
        out_if.ready <= 1'b0;
        repeat (hold) @(posedge clk);
      end
      out_if.ready <= 1'b1;
      run = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 80) : $urandom_range(1, 8);
      repeat (run) @(posedge clk);
    end
  end

  // watchdog: counts cycles in which no request moves on either side
  initial begin
    int unsigned idle_cycles;
    idle_cycles = 0;
    while (idle_cycles < WATCHDOG_LIMIT) begin
      @(negedge clk);
      if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
      end
    end
    $display("DONE: errors detected");
    $finish;
  end

  // stimulus and verdict
  initial begin
    int unsigned r;
    logic [WIDTH_W-1:0] w;
    in_if.valid  <= 1'b0;
    in_if.sample <= '0;
    in_if.flush  <= 1'b0;
    cfg_wr_en    <= 1'b0;
    cfg_index    <= REG_CHANNELS;
    cfg_data     <= '0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    // channels of zero and width of one both fall back to the minimum: two samples
    configure(3'd0, 13'd1);
    send_sample(8'd77, 1'b1);   // flush before any row: dropped
    send_sample(8'd255, 1'b0);  // first row gives nothing
    send_sample(8'd0, 1'b0);
    send_sample(8'd0, 1'b0);    // second row
    send_sample(8'd200, 1'b1);  // flush mid-row copies the sample above
    send_sample(8'd255, 1'b0);
    send_sample(8'd255, 1'b0);
    send_sample(8'd13, 1'b1);   // flush at row start opens the flush row
    send_sample(8'd99, 1'b0);   // still a flush whatever its bit says

    // two channels, two pixels: the row end owes three results
    configure(3'd2, 13'd2);
    send_sample(8'd10, 1'b0);
    send_sample(8'd200, 1'b0);
    send_sample(8'd0, 1'b0);
    send_sample(8'd255, 1'b0);
    send_sample(8'd255, 1'b0);
    send_sample(8'd0, 1'b0);
    send_sample(8'd50, 1'b1);
    send_sample(8'd7, 1'b0);
    send_sample(8'd1, 1'b1);
    send_sample(8'd3, 1'b0);
    send_sample(8'd128, 1'b1);
    send_sample(8'd9, 1'b1);

    // random frames over random settings, out-of-range register values included
    rand_items = 0;
    while (rand_items < 230) begin
      if (rand_items > 60 && !pressure_req) begin
        // a four-channel frame while the receiver holds off, so the block backs up
        configure(3'd4, 13'd8);
        pressure_req = 1'b1;
        quiet = 1'b0;
        random_frame(3);
      end else begin
        if ($urandom_range(0, 1) == 1) begin
          r = $urandom_range(0, 99);
          if (r < 10) w = WIDTH_W'($urandom_range(0, 2));
          else if (r < 75) w = WIDTH_W'($urandom_range(3, 6));
          else w = WIDTH_W'($urandom_range(7, 20));
          configure(CH_W'($urandom_range(0, 7)), w);
        end
        random_frame($urandom_range(1, 3));
      end
      quiet = ($urandom_range(0, 4) == 0);
    end
    quiet = 1'b0;

    drain();
    if (err_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

// ===== median_square_3x3_u8.f =====
sv/msq_pkg.sv
sv/msq_in_if.sv
sv/msq_out_if.sv
sv/msq_ram.sv
sv/msq_ctrl.sv
sv/msq_column.sv
sv/msq_window.sv
sv/msq_median.sv
sv/median_square_3x3_u8.sv
test/msq_checker.sv
test/tb_median_square_3x3_u8.sv
